// ===== hw/rtl/kaf_pkg.sv =====
// Shared types, constants and helpers for the angle Kalman filter.
package kaf_pkg;
    localparam int FRAC_BITS = 16;
    localparam int WORD_W    = 32;
    localparam int Q16_UP    = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int Q16_DN    = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [1:0] alu_op_t;

    localparam alu_op_t OP_ADD = 2'd0;
    localparam alu_op_t OP_SUB = 2'd1;
    localparam alu_op_t OP_MUL = 2'd2;

    localparam logic [1:0] REG_QA    = 2'd0;
    localparam logic [1:0] REG_QB    = 2'd1;
    localparam logic [1:0] REG_R     = 2'd2;
    localparam logic [1:0] REG_INIT  = 2'd3;

    localparam logic [15:0] QA_RESET   = 16'd655;
    localparam logic [15:0] QB_RESET   = 16'd197;
    localparam logic [15:0] R_RESET    = 16'd1966;
    localparam logic signed [25:0] INIT_RESET = 26'sd11796480;

    // Unsigned Q0.16 to FRAC_BITS fraction bits.
    function automatic word_t from_q016(input logic [15:0] v);
        logic [47:0] w;
        w = ({32'd0, v} << Q16_UP) >> Q16_DN;
        return word_t'(w[WORD_W-1:0]);
    endfunction

    function automatic word_t sat33(input logic signed [WORD_W:0] v);
        if (v[WORD_W] != v[WORD_W-1])
            return v[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
        return word_t'(v[WORD_W-1:0]);
    endfunction
endpackage

// ===== hw/rtl/kaf_alu.sv =====
// Shared saturating add, subtract and fixed-point multiply unit.
module kaf_alu (
    input  kaf_pkg::alu_op_t op,
    input  kaf_pkg::word_t   a,
    input  kaf_pkg::word_t   b,
    output kaf_pkg::word_t   y
);
    import kaf_pkg::*;

    logic signed [2*WORD_W-1:0] prod;
    logic signed [2*WORD_W-1:0] prod_sh;
    logic signed [WORD_W:0]     sum;
    logic                       hi_ok;

    always_comb
    begin
        prod    = a * b;
        prod_sh = prod >>> FRAC_BITS;
        hi_ok   = (&prod_sh[2*WORD_W-1:WORD_W-1]) || !(|prod_sh[2*WORD_W-1:WORD_W-1]);
        sum     = {a[WORD_W-1], a} + {b[WORD_W-1], b};
        case (op)
            OP_ADD: y = sat33({a[WORD_W-1], a} + {b[WORD_W-1], b});
            OP_SUB: y = sat33({a[WORD_W-1], a} - {b[WORD_W-1], b});
            OP_MUL:
            begin
                if (hi_ok)
                    y = word_t'(prod_sh[WORD_W-1:0]);
                else if (prod_sh[2*WORD_W-1])
                    y = {1'b1, {(WORD_W-1){1'b0}}};
                else
                    y = {1'b0, {(WORD_W-1){1'b1}}};
            end
            default: y = word_t'(sum[WORD_W-1:0]);
        endcase
    end
endmodule

// ===== hw/rtl/kaf_div.sv =====
// Bit-serial signed divider for the gain: (num << FRAC_BITS) / den, saturated.
module kaf_div (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  kaf_pkg::word_t num,
    input  kaf_pkg::word_t den,
    output logic           done,
    output kaf_pkg::word_t quo
);
    import kaf_pkg::*;

    localparam int NW  = WORD_W + FRAC_BITS;
    localparam int CNW = $clog2(NW + 1);

    logic              busy_reg, busy_next;
    logic [CNW-1:0]    cnt_reg, cnt_next;
    logic [NW-1:0]     q_reg, q_next;
    logic [WORD_W:0]   rem_reg, rem_next;
    logic [WORD_W-1:0] dmag_reg, dmag_next;
    logic              neg_reg, neg_next;
    logic              done_reg, done_next;
    word_t             quo_reg, quo_next;
    logic [WORD_W:0]   rem_sh;
    logic [WORD_W-1:0] nmag;
    logic [NW:0]       qs;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dmag_next = dmag_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        nmag      = num[WORD_W-1] ? WORD_W'(-num) : WORD_W'(num);
        rem_sh    = {rem_reg[WORD_W-1:0], q_reg[NW-1]};
        qs        = neg_reg ? (NW+1)'(-{1'b0, q_reg}) : {1'b0, q_reg};
        if (start)
        begin
            if (den == '0)
            begin
                quo_next  = '0;
                done_next = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
                cnt_next  = CNW'(NW);
                q_next    = {nmag, {FRAC_BITS{1'b0}}};
                rem_next  = '0;
                dmag_next = den[WORD_W-1] ? WORD_W'(-den) : WORD_W'(den);
                neg_next  = num[WORD_W-1] ^ den[WORD_W-1];
            end
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                // saturate the signed quotient
                if (!neg_reg && (|q_reg[NW-1:WORD_W-1]))
                    quo_next = {1'b0, {(WORD_W-1){1'b1}}};
                else if (neg_reg && (|q_reg[NW-1:WORD_W-1]) && (qs[NW:WORD_W-1] != '1))
                    quo_next = {1'b1, {(WORD_W-1){1'b0}}};
                else
                    quo_next = word_t'(qs[WORD_W-1:0]);
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
                if (rem_sh >= {1'b0, dmag_reg})
                begin
                    rem_next = rem_sh - {1'b0, dmag_reg};
                    q_next   = {q_reg[NW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    q_next   = {q_reg[NW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        dmag_reg <= dmag_next;
        neg_reg  <= neg_next;
        quo_reg  <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
endmodule

// ===== hw/rtl/imu_angle_kalman_filter.sv =====
// Top level of the two-state (angle, gyro bias) Kalman filter for tilt angle.
// Each input word (measured angle, gyro rate, time step) runs through a fixed
// program on one shared arithmetic unit, one step per cycle while it is not
// waiting on the divider or the output register: 28 saturating add, subtract
// and Q16.16 multiply steps, one step that snapshots P00 and P01, and one step
// that loads the output register. Two gain divisions run on a bit-serial
// divider that resolves one quotient bit per cycle; each loads its operands,
// resolves the 48-bit quotient, saturates it and hands it over. in_stall is
// high while a word runs through the program, up to its final step, so a new
// word is taken only once the last one is through. The result word is held in
// an output register, so a new input word is taken while it waits; the final
// step of that next word holds until the register is free. Configuration
// writes are taken at any time with cfg_ready always high, and must only be
// issued while the filter is idle; writing initial_angle also loads the angle
// estimate at once. Reset loads the angle estimate from the initial_angle
// reset value and clears the bias and the covariance.
module imu_angle_kalman_filter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [25:0]  measured_angle,
    input  logic signed [27:0]  measured_rate,
    input  logic [15:0]         time_step,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  filtered_angle,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [25:0]         cfg_data
);
    import kaf_pkg::*;

    // Program steps of the sequencer.
    localparam logic [4:0] ST_DIV0 = 5'd15;
    localparam logic [4:0] ST_DIV1 = 5'd16;
    localparam logic [4:0] ST_COPY = 5'd22;
    localparam logic [4:0] ST_LAST = 5'd31;

    // Destination codes for the arithmetic result.
    localparam logic [3:0] D_NONE = 4'd0;
    localparam logic [3:0] D_T    = 4'd1;
    localparam logic [3:0] D_RATE = 4'd2;
    localparam logic [3:0] D_ANG  = 4'd3;
    localparam logic [3:0] D_BIAS = 4'd4;
    localparam logic [3:0] D_P0   = 4'd5;
    localparam logic [3:0] D_P1   = 4'd6;
    localparam logic [3:0] D_P2   = 4'd7;
    localparam logic [3:0] D_P3   = 4'd8;
    localparam logic [3:0] D_S    = 4'd9;
    localparam logic [3:0] D_Y    = 4'd10;

    logic [15:0] qa_reg, qb_reg, r_reg;
    word_t ang_reg, bias_reg, p0_reg, p1_reg, p2_reg, p3_reg;
    word_t meas_reg, rin_reg, dt_reg, t_reg, rate_reg, s_reg, y_reg;
    word_t k0_reg, k1_reg, p00_reg, p01_reg, out_reg;
    logic busy_reg, wait_reg, oval_reg;
    logic [4:0] step_reg;

    alu_op_t op;
    word_t a, b, alu_y, qa, qb, rm;
    logic [3:0] dst;
    logic div_start, div_done;
    word_t div_q;
    logic out_load;

    assign qa = from_q016(qa_reg);
    assign qb = from_q016(qb_reg);
    assign rm = from_q016(r_reg);

    // Program table: one arithmetic step per entry.
    always_comb
    begin
        op  = OP_ADD;
        a   = '0;
        b   = '0;
        dst = D_NONE;
        case (step_reg)
            5'd0:  begin op = OP_SUB; a = rin_reg; b = bias_reg; dst = D_RATE; end
            5'd1:  begin op = OP_MUL; a = dt_reg;  b = rate_reg; dst = D_T;    end
            5'd2:  begin op = OP_ADD; a = ang_reg; b = t_reg;    dst = D_ANG;  end
            5'd3:  begin op = OP_MUL; a = dt_reg;  b = p3_reg;   dst = D_T;    end
            5'd4:  begin op = OP_SUB; a = t_reg;   b = p1_reg;   dst = D_T;    end
            5'd5:  begin op = OP_SUB; a = t_reg;   b = p2_reg;   dst = D_T;    end
            5'd6:  begin op = OP_ADD; a = t_reg;   b = qa;       dst = D_T;    end
            5'd7:  begin op = OP_MUL; a = dt_reg;  b = t_reg;    dst = D_T;    end
            5'd8:  begin op = OP_ADD; a = p0_reg;  b = t_reg;    dst = D_P0;   end
            5'd9:  begin op = OP_MUL; a = dt_reg;  b = p3_reg;   dst = D_T;    end
            5'd10: begin op = OP_SUB; a = p1_reg;  b = t_reg;    dst = D_P1;   end
            5'd11: begin op = OP_SUB; a = p2_reg;  b = t_reg;    dst = D_P2;   end
            5'd12: begin op = OP_MUL; a = qb;      b = dt_reg;   dst = D_T;    end
            5'd13: begin op = OP_ADD; a = p3_reg;  b = t_reg;    dst = D_P3;   end
            5'd14: begin op = OP_ADD; a = p0_reg;  b = rm;       dst = D_S;    end
            5'd17: begin op = OP_SUB; a = meas_reg; b = ang_reg; dst = D_Y;    end
            5'd18: begin op = OP_MUL; a = k0_reg;  b = y_reg;    dst = D_T;    end
            5'd19: begin op = OP_ADD; a = ang_reg; b = t_reg;    dst = D_ANG;  end
            5'd20: begin op = OP_MUL; a = k1_reg;  b = y_reg;    dst = D_T;    end
            5'd21: begin op = OP_ADD; a = bias_reg; b = t_reg;   dst = D_BIAS; end
            5'd23: begin op = OP_MUL; a = k0_reg;  b = p00_reg;  dst = D_T;    end
            5'd24: begin op = OP_SUB; a = p0_reg;  b = t_reg;    dst = D_P0;   end
            5'd25: begin op = OP_MUL; a = k0_reg;  b = p01_reg;  dst = D_T;    end
            5'd26: begin op = OP_SUB; a = p1_reg;  b = t_reg;    dst = D_P1;   end
            5'd27: begin op = OP_MUL; a = k1_reg;  b = p00_reg;  dst = D_T;    end
            5'd28: begin op = OP_SUB; a = p2_reg;  b = t_reg;    dst = D_P2;   end
            5'd29: begin op = OP_MUL; a = k1_reg;  b = p01_reg;  dst = D_T;    end
            5'd30: begin op = OP_SUB; a = p3_reg;  b = t_reg;    dst = D_P3;   end
            default: dst = D_NONE;
        endcase
    end

    kaf_alu u_alu (
        .op (op),
        .a  (a),
        .b  (b),
        .y  (alu_y)
    );

    // Kick the divider once on entry to each gain step.
    assign div_start = busy_reg && !wait_reg &&
                       ((step_reg == ST_DIV0) || (step_reg == ST_DIV1));

    kaf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ((step_reg == ST_DIV0) ? p0_reg : p2_reg),
        .den   (s_reg),
        .done  (div_done),
        .quo   (div_q)
    );

    // Final step loads the output register once it is free.
    assign out_load = busy_reg && (step_reg == ST_LAST) && (!oval_reg || !out_stall);

    assign in_stall       = busy_reg;
    assign out_valid      = oval_reg;
    assign filtered_angle = out_reg;
    assign cfg_ready      = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qa_reg   <= QA_RESET;
            qb_reg   <= QB_RESET;
            r_reg    <= R_RESET;
            ang_reg  <= word_t'(INIT_RESET);
            bias_reg <= '0;
            p0_reg   <= '0;
            p1_reg   <= '0;
            p2_reg   <= '0;
            p3_reg   <= '0;
            busy_reg <= 1'b0;
            wait_reg <= 1'b0;
            oval_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            if (out_load)
                oval_reg <= 1'b1;
            else if (!out_stall)
                oval_reg <= 1'b0;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_QA:   qa_reg <= cfg_data[15:0];
                    REG_QB:   qb_reg <= cfg_data[15:0];
                    REG_R:    r_reg  <= cfg_data[15:0];
                    REG_INIT: ang_reg <= word_t'($signed(cfg_data));
                    default: ;
                endcase
            end
            if (!busy_reg)
            begin
                if (in_valid)
                begin
                    busy_reg <= 1'b1;
                    step_reg <= '0;
                end
            end
            else
            begin
                case (dst)
                    D_ANG:  ang_reg  <= alu_y;
                    D_BIAS: bias_reg <= alu_y;
                    D_P0:   p0_reg   <= alu_y;
                    D_P1:   p1_reg   <= alu_y;
                    D_P2:   p2_reg   <= alu_y;
                    D_P3:   p3_reg   <= alu_y;
                    default: ;
                endcase
                if ((step_reg == ST_DIV0) || (step_reg == ST_DIV1))
                begin
                    // hold until the quotient arrives
                    if (!wait_reg)
                        wait_reg <= 1'b1;
                    else if (div_done)
                    begin
                        wait_reg <= 1'b0;
                        step_reg <= step_reg + 1'b1;
                    end
                end
                else if (step_reg == ST_LAST)
                begin
                    // drop the result into the output register once it is free
                    if (out_load)
                        busy_reg <= 1'b0;
                end
                else
                    step_reg <= step_reg + 1'b1;
            end
        end
    end

    // Working registers: no reset needed.
    always_ff @(posedge clk)
    begin
        if (!busy_reg && in_valid)
        begin
            meas_reg <= word_t'(measured_angle);
            rin_reg  <= word_t'(measured_rate);
            dt_reg   <= from_q016(time_step);
        end
        case (dst)
            D_T:    t_reg    <= alu_y;
            D_RATE: rate_reg <= alu_y;
            D_S:    s_reg    <= alu_y;
            D_Y:    y_reg    <= alu_y;
            default: ;
        endcase
        if (busy_reg && wait_reg && div_done)
        begin
            if (step_reg == ST_DIV0)
                k0_reg <= div_q;
            else
                k1_reg <= div_q;
        end
        if (step_reg == ST_COPY)
        begin
            p00_reg <= p0_reg;
            p01_reg <= p1_reg;
        end
        if (out_load)
            out_reg <= ang_reg;
    end

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> busy_reg)
        else $error("accepted word did not start the sequencer");
    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(busy_reg) && $past(step_reg) == ST_LAST)
        else $error("result shown outside the final step");
    a_div_in_gain: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> busy_reg && (step_reg == ST_DIV0 || step_reg == ST_DIV1))
        else $error("quotient arrived outside a gain step");
    a_wait_in_gain: assert property (@(posedge clk) disable iff (!rst_n)
        wait_reg |-> (step_reg == ST_DIV0 || step_reg == ST_DIV1))
        else $error("divider wait outside a gain step");
endmodule
